/* rtl/core/vrm_pkg.sv */
// ----------------------------------------------------------------------------
// vrm_pkg: shared types and constants for the voxel ray march
// Holds the item codes, the controller states, the command and status
// bundles between controller and datapath, and the fixed-point helpers.
// ----------------------------------------------------------------------------
package vrm_pkg;

  // default sizes
  localparam int GRID_SIZE_DEF = 32;
  localparam int TILE_BITS_DEF = 8;
  localparam int MAX_STEPS_DEF = 256;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 1'b1;
  localparam logic [15:0] RAY_LENGTH_RST = 16'd4096;  // 16.0
  localparam logic [15:0] STEP_SIZE_RST  = 16'd128;   // 0.5

  // sample arithmetic: origin Q8.8 scaled by 2^14, plus i (Q8.8) * dir (Q2.14)
  localparam int ACC_W      = 34;
  localparam int FRAC_SHIFT = 22;
  localparam int CELL_W     = 12;
  localparam int FOUND_W    = 10;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_AIR   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_REJECT = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;   // write one zero entry of the store
    logic load;    // take the input item
    logic exec;    // perform write, or set up a cast
    logic march;   // one sample step
    logic finish;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic lat_cast;
    logic march_done;
    logic out_free;
  } sts_t;

  // truncate a Q.22 position toward zero to a signed cell index
  function automatic logic signed [CELL_W-1:0] trunc_cell(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0]  mag;
    logic [CELL_W-1:0] m;
    mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    m   = mag[FRAC_SHIFT +: CELL_W];
    return s[ACC_W-1] ? CELL_W'(-m) : m;
  endfunction

  // clamp a cell index to the reported range
  function automatic logic signed [FOUND_W-1:0] sat_cell(input logic signed [CELL_W-1:0] c);
    logic signed [FOUND_W-1:0] r;
    if (c > $signed(CELL_W'(511))) begin
      r = FOUND_W'(511);
    end else if (c < $signed(-CELL_W'(512))) begin
      r = FOUND_W'(-512);
    end else begin
      r = c[FOUND_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/voxel_ray_march.sv */
// ----------------------------------------------------------------------------
// voxel_ray_march: fixed-step ray march over a cubic voxel tile store
// Write items fill cells of the store; cast items march a ray through it and
// report the first solid cell or the last air cell before it.
// ----------------------------------------------------------------------------
// After reset the block sweeps the store to air, one entry a cycle, over all
// GRID_SIZE^3 entries (32768 at the default size) and takes no item until the
// sweep is done; configuration writes are taken throughout. A write item
// passes through three steps: accept, write, result load. A cast item is
// accepted, set up, marched sample by sample and loaded into the result
// register; the samples are the points actually visited (at most MAX_STEPS,
// and no more than ceil(ray_length / step_size) for a non-zero step), and a
// cast with a zero length visits nothing. The march visits one sample a cycle
// because the single store read port is issued speculatively for the next
// point while the previous read is being checked, so the store port sets the
// pace; a miss waits for the last read to drain before it finishes. With the
// reset length of 16.0 and step of 0.5 a full miss visits 32 samples. Items
// are handled one at a time; a finished result waits in the output register
// while the next item is accepted and worked on.
// ----------------------------------------------------------------------------
module voxel_ray_march #(
  parameter int GRID_SIZE = vrm_pkg::GRID_SIZE_DEF,
  parameter int TILE_BITS = vrm_pkg::TILE_BITS_DEF,
  parameter int MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [vrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vrm_pkg::CFG_DATA_W-1:0] cfg_data,
  // input item
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [5:0]                     cell_x,
  input  logic [5:0]                     cell_y,
  input  logic [5:0]                     cell_z,
  input  logic [7:0]                     tile_value,
  input  logic signed [15:0]             origin_x,
  input  logic signed [15:0]             origin_y,
  input  logic signed [15:0]             origin_z,
  input  logic signed [15:0]             dir_x,
  input  logic signed [15:0]             dir_y,
  input  logic signed [15:0]             dir_z,
  // result item
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic signed [9:0]              found_x,
  output logic signed [9:0]              found_y,
  output logic signed [9:0]              found_z,
  output logic                           air_valid,
  output logic [7:0]                     hit_tile
);

  import vrm_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);

  cmd_t cmd;
  sts_t sts;

  // store port between datapath and store
  logic                 st_we;
  logic [ADDR_W-1:0]    st_waddr;
  logic [TILE_BITS-1:0] st_wdata;
  logic [ADDR_W-1:0]    st_raddr;
  logic [TILE_BITS-1:0] st_rdata;

  // sequence the sweep, the item steps and the result hand-off
  vrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold configuration, the item, the sample accumulators and the result
  vrm_dp #(
    .GRID_SIZE (GRID_SIZE),
    .TILE_BITS (TILE_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .tile_value (tile_value),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .origin_z   (origin_z),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .found_x    (found_x),
    .found_y    (found_y),
    .found_z    (found_z),
    .air_valid  (air_valid),
    .hit_tile   (hit_tile),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata)
  );

  // tile store: one write, one registered read a cycle
  vrm_store #(
    .DEPTH  (CELLS),
    .DATA_W (TILE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

/* rtl/core/vrm_store.sv */
// ----------------------------------------------------------------------------
// vrm_store: voxel tile store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vrm_store #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/vrm_ctrl.sv */
// ----------------------------------------------------------------------------
// vrm_ctrl: sequencer for the voxel ray march
// Clears the store after reset, then runs one item at a time.
// ----------------------------------------------------------------------------
module vrm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  vrm_pkg::sts_t sts,
  output vrm_pkg::cmd_t cmd
);

  import vrm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (sts.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  state_next = sts.lat_cast ? ST_MARCH : ST_DONE;
      ST_MARCH: if (sts.march_done) state_next = ST_DONE;
      ST_DONE:  if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_MARCH: cmd.march = 1'b1;
      ST_DONE:  cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

/* rtl/core/vrm_dp.sv */
// ----------------------------------------------------------------------------
// vrm_dp: datapath for the voxel ray march
// Holds the registers, the item latch, the sample accumulators, the march
// bookkeeping, the store port drive and the result register.
// ----------------------------------------------------------------------------
module vrm_dp #(
  parameter int GRID_SIZE = vrm_pkg::GRID_SIZE_DEF,
  parameter int TILE_BITS = vrm_pkg::TILE_BITS_DEF,
  parameter int MAX_STEPS = vrm_pkg::MAX_STEPS_DEF,
  localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE * GRID_SIZE)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vrm_pkg::cmd_t                     cmd,
  output vrm_pkg::sts_t                     sts,
  input  logic                              cfg_write,
  input  logic [vrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vrm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]                        kind,
  input  logic [5:0]                        cell_x,
  input  logic [5:0]                        cell_y,
  input  logic [5:0]                        cell_z,
  input  logic [7:0]                        tile_value,
  input  logic signed [15:0]                origin_x,
  input  logic signed [15:0]                origin_y,
  input  logic signed [15:0]                origin_z,
  input  logic signed [15:0]                dir_x,
  input  logic signed [15:0]                dir_y,
  input  logic signed [15:0]                dir_z,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [1:0]                        status,
  output logic signed [9:0]                 found_x,
  output logic signed [9:0]                 found_y,
  output logic signed [9:0]                 found_z,
  output logic                              air_valid,
  output logic [7:0]                        hit_tile,
  output logic                              st_we,
  output logic [ADDR_W-1:0]                 st_waddr,
  output logic [TILE_BITS-1:0]              st_wdata,
  output logic [ADDR_W-1:0]                 st_raddr,
  input  logic [TILE_BITS-1:0]              st_rdata
);

  import vrm_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int NW     = $clog2(MAX_STEPS + 1);

  // configuration
  logic [15:0] ray_len;
  logic [15:0] step;

  // item latch
  kind_t       lat_kind;
  logic [5:0]  lat_cx, lat_cy, lat_cz;
  logic [7:0]  lat_tile;
  logic signed [15:0] lat_dx, lat_dy, lat_dz;

  // march state
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
  logic signed [ACC_W-1:0] dlt_x, dlt_y, dlt_z;
  logic [16:0]             i_pos;
  logic [NW-1:0]           n_cnt;
  logic                    p_valid, p_ing;
  logic signed [CELL_W-1:0] p_x, p_y, p_z;
  logic                    res_hit, res_air;
  logic [7:0]              res_tile;
  logic signed [CELL_W-1:0] h_x, h_y, h_z, a_x, a_y, a_z;

  logic [ADDR_W-1:0] clr_cnt;

  logic signed [CELL_W-1:0] c_x, c_y, c_z;
  logic                     c_ing;
  logic                     more, hit_now, issue, wr_ok, lat_cast;
  logic signed [32:0]       prod_x, prod_y, prod_z;
  logic [TILE_BITS+7:0]     w_ext, r_ext;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y,
                                                  input logic [5:0] z);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(ADDR_W'(z) * ADDR_W'(GRID_SIZE) + ADDR_W'(y));
    r = ADDR_W'(r * ADDR_W'(GRID_SIZE) + ADDR_W'(x));
    return r;
  endfunction

  function automatic logic in_grid(input logic signed [CELL_W-1:0] c);
    return (c >= $signed(CELL_W'(0))) && (c < $signed(CELL_W'(GRID_SIZE)));
  endfunction

  // ---- sample point of the accumulators
  always_comb begin
    c_x   = trunc_cell(acc_x);
    c_y   = trunc_cell(acc_y);
    c_z   = trunc_cell(acc_z);
    c_ing = in_grid(c_x) && in_grid(c_y) && in_grid(c_z);
  end

  assign st_raddr = cell_addr(c_x[5:0], c_y[5:0], c_z[5:0]);

  assign lat_cast = (lat_kind == KIND_FIRST) || (lat_kind == KIND_AIR);
  assign wr_ok    = (lat_kind == KIND_WRITE) && ({1'b0, lat_cx} < 7'(GRID_SIZE))
                    && ({1'b0, lat_cy} < 7'(GRID_SIZE)) && ({1'b0, lat_cz} < 7'(GRID_SIZE));

  assign more    = (i_pos < {1'b0, ray_len}) && (n_cnt < NW'(MAX_STEPS));
  assign hit_now = p_valid && p_ing && (st_rdata != '0);
  assign issue   = !hit_now && more;

  assign w_ext = {{TILE_BITS{1'b0}}, lat_tile};
  assign r_ext = {8'b0, st_rdata};

  // ---- store write: clearing sweep or write item
  always_comb begin
    st_we    = cmd.clear || (cmd.exec && wr_ok);
    st_waddr = cmd.clear ? clr_cnt : cell_addr(lat_cx, lat_cy, lat_cz);
    st_wdata = cmd.clear ? '0 : w_ext[TILE_BITS-1:0];
  end

  assign prod_x = $signed({1'b0, step}) * lat_dx;
  assign prod_y = $signed({1'b0, step}) * lat_dy;
  assign prod_z = $signed({1'b0, step}) * lat_dz;

  always_comb begin
    sts.clear_last = (clr_cnt == ADDR_W'(CELLS - 1));
    sts.lat_cast   = lat_cast;
    sts.march_done = hit_now || (!more && !p_valid);
    sts.out_free   = !out_valid || out_ready;
  end

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_len <= RAY_LENGTH_RST;
      step    <= STEP_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RAY_LENGTH: ray_len <= cfg_data;
        REG_STEP_SIZE:  step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= ADDR_W'(clr_cnt + 1'b1);
    end
  end

  // ---- item latch and accumulator start
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_kind <= kind_t'(kind);
      lat_cx   <= cell_x;
      lat_cy   <= cell_y;
      lat_cz   <= cell_z;
      lat_tile <= tile_value;
      lat_dx   <= dir_x;
      lat_dy   <= dir_y;
      lat_dz   <= dir_z;
      acc_x    <= {{4{origin_x[15]}}, origin_x, 14'b0};
      acc_y    <= {{4{origin_y[15]}}, origin_y, 14'b0};
      acc_z    <= {{4{origin_z[15]}}, origin_z, 14'b0};
    end else if (cmd.march && issue) begin
      acc_x <= ACC_W'(acc_x + dlt_x);
      acc_y <= ACC_W'(acc_y + dlt_y);
      acc_z <= ACC_W'(acc_z + dlt_z);
    end
  end

  // ---- march bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.exec) begin
      p_valid <= 1'b0;
    end else if (cmd.march) begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dlt_x    <= ACC_W'(prod_x);
      dlt_y    <= ACC_W'(prod_y);
      dlt_z    <= ACC_W'(prod_z);
      i_pos    <= '0;
      n_cnt    <= '0;
      res_hit  <= 1'b0;
      res_air  <= 1'b0;
      res_tile <= '0;
      h_x <= '0; h_y <= '0; h_z <= '0;
      a_x <= '0; a_y <= '0; a_z <= '0;
    end else if (cmd.march) begin
      if (hit_now) begin
        res_hit  <= 1'b1;
        res_tile <= r_ext[7:0];
        h_x <= p_x; h_y <= p_y; h_z <= p_z;
      end else if (p_valid) begin
        res_air <= 1'b1;
        a_x <= p_x; a_y <= p_y; a_z <= p_z;
      end
      if (issue) begin
        i_pos <= 17'(i_pos + {1'b0, step});
        n_cnt <= NW'(n_cnt + 1'b1);
        p_x   <= c_x;
        p_y   <= c_y;
        p_z   <= c_z;
        p_ing <= c_ing;
      end
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (lat_cast) begin
        status    <= res_hit ? STAT_DONE : STAT_MISS;
        air_valid <= res_air;
        hit_tile  <= res_tile;
        if (lat_kind == KIND_FIRST) begin
          found_x <= sat_cell(h_x);
          found_y <= sat_cell(h_y);
          found_z <= sat_cell(h_z);
        end else begin
          found_x <= sat_cell(a_x);
          found_y <= sat_cell(a_y);
          found_z <= sat_cell(a_z);
        end
      end else begin
        status    <= wr_ok ? STAT_DONE : STAT_REJECT;
        air_valid <= 1'b0;
        hit_tile  <= '0;
        found_x   <= '0;
        found_y   <= '0;
        found_z   <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_march: assert property (@(posedge clk) disable iff (rst)
    cmd.march |-> !st_we) else $error("store written during march");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.march |-> n_cnt <= NW'(MAX_STEPS)) else $error("sample count past bound");
  a_hit_recorded: assert property (@(posedge clk) disable iff (rst)
    cmd.march && hit_now |=> res_hit) else $error("hit not recorded");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result lost on finish");
`endif

endmodule

/* tb/sv/voxel_ray_march_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_ray_march_tb: self-checking bench for the voxel ray march
// Walks a short table of directed writes and casts, then runs phases of
// random writes, casts and reserved kinds under several length and step
// settings. A shadow copy of the tile store and both registers traces every
// cast, and each result item is compared with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module voxel_ray_march_tb;
  import vrm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int GRID           = GRID_SIZE_DEF;
  localparam int MAX_STEPS      = MAX_STEPS_DEF;
  localparam int CELLS          = GRID * GRID * GRID;
  // the clearing sweep after reset accepts nothing until all CELLS entries are cleared
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES    = MAX_STEPS + 16;
  localparam int PHASES         = 8;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         cx;
    logic [5:0]         cy;
    logic [5:0]         cz;
    logic [7:0]         tile;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } vox_item_t;

  typedef struct packed {
    stat_t             status;
    logic signed [9:0] fx;
    logic signed [9:0] fy;
    logic signed [9:0] fz;
    logic              air;
    logic [7:0]        tile;
  } vox_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                what;
    vox_item_t                item;
    logic [CFG_IDX_W-1:0]     reg_index;
    logic [CFG_DATA_W-1:0]    reg_value;
    bit                       typed;
    vox_result_t              res;
  } plan_row_t;

  // ports of the block
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               kind;
  logic [5:0]               cell_x;
  logic [5:0]               cell_y;
  logic [5:0]               cell_z;
  logic [7:0]               tile_value;
  logic signed [15:0]       origin_x;
  logic signed [15:0]       origin_y;
  logic signed [15:0]       origin_z;
  logic signed [15:0]       dir_x;
  logic signed [15:0]       dir_y;
  logic signed [15:0]       dir_z;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic signed [9:0]        found_x;
  logic signed [9:0]        found_y;
  logic signed [9:0]        found_z;
  logic                     air_valid;
  logic [7:0]               hit_tile;

  // shadow of the block's state
  logic [7:0]               shadow_tiles [CELLS];
  logic [15:0]              len_shadow;
  logic [15:0]              step_shadow;

  vox_result_t              answers_q [$];
  plan_row_t                plan [$];
  int                       err_count   = 0;
  int                       quiet_cycles = 0;
  bit                       tx_idle     = 1'b0;
  bit                       rx_idle     = 1'b0;

  int phase_items [PHASES] = '{300, 80, 150, 250, 200, 200, 200, 220};
  int phase_len   [PHASES] = '{4096, 65535, 65535, 1024, -1, 16384, -1, 4096};
  int phase_step  [PHASES] = '{128, 1, 65535, 32, -1, 256, -1, 128};

  voxel_ray_march dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .tile_value (tile_value),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .origin_z   (origin_z),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_x    (found_x),
    .found_y    (found_y),
    .found_z    (found_z),
    .air_valid  (air_valid),
    .hit_tile   (hit_tile)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tracing the ray
  // ---------------------------------------------------------------------------

  // Position is origin * 2^14 + pos * dir in Q.22, truncated toward zero, so
  // cell 0 covers (-1, 1) on each axis.
  function automatic int sample_cell(input int org, input longint pos, input int dir);
    longint s;
    s = longint'(org) * 64'sd16384 + pos * longint'(dir);
    if (s < 0) begin
      return -int'((-s) >> 22);
    end
    return int'(s >> 22);
  endfunction

  // saturate a cell index to the range of the found fields
  function automatic logic signed [9:0] clamp_found(input int c);
    if (c > 511) begin
      return 10'sd511;
    end else if (c < -512) begin
      return -10'sd512;
    end
    return 10'(c);
  endfunction

  // Work out the result item of one accepted item and apply any store write.
  function automatic vox_result_t resolve_item(input vox_item_t it);
    vox_result_t r;
    longint      pos;
    int          n;
    int          cx, cy, cz;
    int          ax, ay, az;
    int          hx, hy, hz;
    logic [7:0]  t;
    logic [7:0]  got;
    bit          hit;
    bit          air;
    r   = '0;
    pos = 0;
    n   = 0;
    hit = 1'b0;
    air = 1'b0;
    got = '0;
    ax = 0; ay = 0; az = 0;
    hx = 0; hy = 0; hz = 0;
    if (it.kind == KIND_WRITE) begin
      if (it.cx >= GRID || it.cy >= GRID || it.cz >= GRID) begin
        r.status = STAT_REJECT;
      end else begin
        shadow_tiles[(int'(it.cz) * GRID + int'(it.cy)) * GRID + int'(it.cx)] = it.tile;
        r.status = STAT_DONE;
      end
    end else if (it.kind == KIND_RSVD) begin
      r.status = STAT_REJECT;
    end else begin
      while (pos < longint'(len_shadow) && n < MAX_STEPS) begin
        cx = sample_cell(it.ox, pos, it.dx);
        cy = sample_cell(it.oy, pos, it.dy);
        cz = sample_cell(it.oz, pos, it.dz);
        // outside the grid everything is air
        t = '0;
        if (cx >= 0 && cx < GRID && cy >= 0 && cy < GRID && cz >= 0 && cz < GRID) begin
          t = shadow_tiles[(cz * GRID + cy) * GRID + cx];
        end
        if (t != 0) begin
          hit = 1'b1;
          got = t;
          hx = cx; hy = cy; hz = cz;
          break;
        end
        air = 1'b1;
        ax = cx; ay = cy; az = cz;
        pos += longint'(step_shadow);
        n++;
      end
      r.status = hit ? STAT_DONE : STAT_MISS;
      r.air    = air;
      r.tile   = hit ? got : 8'd0;
      if (it.kind == KIND_FIRST && hit) begin
        r.fx = clamp_found(hx);
        r.fy = clamp_found(hy);
        r.fz = clamp_found(hz);
      end else if (it.kind == KIND_AIR && air) begin
        r.fx = clamp_found(ax);
        r.fy = clamp_found(ay);
        r.fz = clamp_found(az);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Building items and table rows
  // ---------------------------------------------------------------------------

  function automatic vox_item_t mk_write(input int x, input int y, input int z,
                                         input int tile);
    vox_item_t it;
    it      = '0;
    it.kind = KIND_WRITE;
    it.cx   = 6'(x);
    it.cy   = 6'(y);
    it.cz   = 6'(z);
    it.tile = 8'(tile);
    return it;
  endfunction

  function automatic vox_item_t mk_cast(input kind_t k, input int ox, input int oy,
                                        input int oz, input int dx, input int dy,
                                        input int dz);
    vox_item_t it;
    it      = '0;
    it.kind = k;
    it.ox   = 16'(ox);
    it.oy   = 16'(oy);
    it.oz   = 16'(oz);
    it.dx   = 16'(dx);
    it.dy   = 16'(dy);
    it.dz   = 16'(dz);
    return it;
  endfunction

  function automatic vox_result_t mk_res(input stat_t s, input int fx, input int fy,
                                         input int fz, input bit air, input int tile);
    vox_result_t r;
    r.status = s;
    r.fx     = 10'(fx);
    r.fy     = 10'(fy);
    r.fz     = 10'(fz);
    r.air    = air;
    r.tile   = 8'(tile);
    return r;
  endfunction

  function automatic void add_item(input vox_item_t it, input bit typed,
                                   input vox_result_t res);
    plan_row_t row;
    row.what      = ROW_ITEM;
    row.item      = it;
    row.reg_index = '0;
    row.reg_value = '0;
    row.typed     = typed;
    row.res       = res;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row.what      = ROW_CFG;
    row.item      = '0;
    row.reg_index = idx;
    row.reg_value = value;
    row.typed     = 1'b0;
    row.res       = '0;
    plan.push_back(row);
  endfunction

  // Random item: writes favour a dense box in the middle of the grid so that
  // casts, mostly started inside or just around the grid, hit something.
  function automatic vox_item_t random_item();
    vox_item_t   it;
    int unsigned pick;
    int unsigned shape;
    pick    = $urandom_range(0, 99);
    it.kind = KIND_RSVD;
    it.cx   = 6'($urandom);
    it.cy   = 6'($urandom);
    it.cz   = 6'($urandom);
    it.tile = 8'($urandom);
    it.ox   = 16'($urandom);
    it.oy   = 16'($urandom);
    it.oz   = 16'($urandom);
    it.dx   = 16'($urandom);
    it.dy   = 16'($urandom);
    it.dz   = 16'($urandom);
    if (pick < 35) begin
      it.kind = KIND_WRITE;
      shape   = $urandom_range(0, 19);
      if (shape < 13) begin
        it.cx = 6'($urandom_range(8, 23));
        it.cy = 6'($urandom_range(8, 23));
        it.cz = 6'($urandom_range(8, 23));
      end else if (shape < 18) begin
        it.cx = 6'($urandom_range(0, GRID - 1));
        it.cy = 6'($urandom_range(0, GRID - 1));
        it.cz = 6'($urandom_range(0, GRID - 1));
      end else begin
        // push one axis out of the grid
        case ($urandom_range(0, 2))
          0:       it.cx[5] = 1'b1;
          1:       it.cy[5] = 1'b1;
          default: it.cz[5] = 1'b1;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        it.tile = '0;
      end
    end else if (pick < 97) begin
      it.kind = (pick < 66) ? KIND_FIRST : KIND_AIR;
      if ($urandom_range(0, 4) != 0) begin
        it.ox = 16'($urandom_range(0, 8703) - 256);
        it.oy = 16'($urandom_range(0, 8703) - 256);
        it.oz = 16'($urandom_range(0, 8703) - 256);
      end
      shape = $urandom_range(0, 19);
      if (shape < 14) begin
        it.dx = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.dy = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.dz = 16'(int'($urandom_range(0, 32768)) - 16384);
      end else if (shape < 19) begin
        it.dx = '0;
        it.dy = '0;
        it.dz = '0;
        case ($urandom_range(0, 2))
          0:       it.dx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
          1:       it.dy = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
          default: it.dz = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        endcase
      end
      // otherwise keep the full-width direction as drawn
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one item from the falling edge and hold it until it is taken.
  task automatic push_item(input vox_item_t it, input bit typed, input vox_result_t res);
    vox_result_t traced;
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= it.kind;
    cell_x     <= it.cx;
    cell_y     <= it.cy;
    cell_z     <= it.cz;
    tile_value <= it.tile;
    origin_x   <= it.ox;
    origin_y   <= it.oy;
    origin_z   <= it.oz;
    dir_x      <= it.dx;
    dir_y      <= it.dy;
    dir_z      <= it.dz;
    do begin
      @(posedge clk);
    end while (!in_ready);
    // trace every item so that the shadow store follows writes, but queue the
    // typed answer where the table gives one
    traced = resolve_item(it);
    answers_q.push_back(typed ? res : traced);
  endtask

  // While idling is enabled, now and then drop valid for a random burst.
  task automatic sender_gap();
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every outstanding answer has been matched.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_RAY_LENGTH) begin
      len_shadow = value;
    end else begin
      step_shadow = value;
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver: stall in random bursts while enabled.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    vox_result_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        $error("result item with no answer outstanding");
        err_count++;
      end else begin
        want = answers_q.pop_front();
        compare_field("status", {14'd0, want.status}, {14'd0, status});
        compare_field("found_x", want.fx, found_x);
        compare_field("found_y", want.fy, found_y);
        compare_field("found_z", want.fz, found_z);
        compare_field("air_valid", {15'd0, want.air}, {15'd0, air_valid});
        compare_field("hit_tile", {8'd0, want.tile}, {8'd0, hit_tile});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // drive every input to a known value before the first edge
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = '0;
    cell_x     = '0;
    cell_y     = '0;
    cell_z     = '0;
    tile_value = '0;
    origin_x   = '0;
    origin_y   = '0;
    origin_z   = '0;
    dir_x      = '0;
    dir_y      = '0;
    dir_z      = '0;
    foreach (shadow_tiles[k]) shadow_tiles[k] = '0;
    len_shadow  = RAY_LENGTH_RST;
    step_shadow = STEP_SIZE_RST;

    // Directed table. Rows with a typed answer are plain to read: empty store,
    // extremes, rejects. The rest are traced.
    // empty store at reset settings: 16.0 long, 0.5 apart
    add_item(mk_cast(KIND_FIRST, 0, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_MISS, 0, 0, 0, 1'b1, 0));
    add_item(mk_cast(KIND_AIR, 0, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_MISS, 15, 0, 0, 1'b1, 0));
    // far corner, then a cast that starts inside it
    add_item(mk_write(31, 31, 31, 255), 1'b1, mk_res(STAT_DONE, 0, 0, 0, 1'b0, 0));
    add_item(mk_cast(KIND_FIRST, 8064, 8064, 8064, 0, 0, 0), 1'b1,
             mk_res(STAT_DONE, 31, 31, 31, 1'b0, 255));
    // out-of-grid writes on each axis
    add_item(mk_write(32, 0, 0, 1), 1'b1, mk_res(STAT_REJECT, 0, 0, 0, 1'b0, 0));
    add_item(mk_write(0, 63, 0, 1), 1'b1, mk_res(STAT_REJECT, 0, 0, 0, 1'b0, 0));
    add_item(mk_write(0, 0, 63, 170), 1'b1, mk_res(STAT_REJECT, 0, 0, 0, 1'b0, 0));
    // first sample already solid, both cast modes
    add_item(mk_write(0, 0, 0, 90), 1'b1, mk_res(STAT_DONE, 0, 0, 0, 1'b0, 0));
    add_item(mk_cast(KIND_FIRST, 0, 0, 0, 0, 0, 16384), 1'b1,
             mk_res(STAT_DONE, 0, 0, 0, 1'b0, 90));
    add_item(mk_cast(KIND_AIR, 0, 0, 0, 0, 0, 16384), 1'b1,
             mk_res(STAT_DONE, 0, 0, 0, 1'b0, 90));
    // undefined kind behaves as a rejected write
    add_item(mk_cast(KIND_RSVD, -1, -1, -1, -1, -1, -1), 1'b1,
             mk_res(STAT_REJECT, 0, 0, 0, 1'b0, 0));
    // hit along +x after some air, both modes
    add_item(mk_write(5, 0, 0, 51), 1'b1, mk_res(STAT_DONE, 0, 0, 0, 1'b0, 0));
    add_item(mk_cast(KIND_FIRST, 256, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_DONE, 5, 0, 0, 1'b1, 51));
    add_item(mk_cast(KIND_AIR, 256, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_DONE, 4, 0, 0, 1'b1, 51));
    // a negative fraction truncates into cell 0
    add_item(mk_cast(KIND_FIRST, -192, 0, 0, 0, 0, 0), 1'b1,
             mk_res(STAT_DONE, 0, 0, 0, 1'b0, 90));
    // clear the corner back to air and march the diagonal through it
    add_item(mk_write(31, 31, 31, 0), 1'b1, mk_res(STAT_DONE, 0, 0, 0, 1'b0, 0));
    add_item(mk_cast(KIND_AIR, 8064, 8064, 8064, -16384, -16384, -16384), 1'b0, '0);
    // no samples at all
    add_cfg(REG_RAY_LENGTH, 16'd0);
    add_item(mk_cast(KIND_FIRST, 256, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_MISS, 0, 0, 0, 1'b0, 0));
    add_item(mk_cast(KIND_AIR, 256, 0, 0, 16384, 0, 0), 1'b1,
             mk_res(STAT_MISS, 0, 0, 0, 1'b0, 0));
    // zero step: the origin cell over and over up to the step bound
    add_cfg(REG_RAY_LENGTH, 16'd4096);
    add_cfg(REG_STEP_SIZE, 16'd0);
    add_item(mk_cast(KIND_AIR, 2560, 2560, 2560, 16384, 16384, 16384), 1'b1,
             mk_res(STAT_MISS, 10, 10, 10, 1'b1, 0));
    add_item(mk_cast(KIND_FIRST, 1408, 0, 0, -16384, 0, 0), 1'b1,
             mk_res(STAT_DONE, 5, 0, 0, 1'b0, 51));
    // longest length, unit step, near-2.0 directions: last air cell saturates
    add_cfg(REG_RAY_LENGTH, 16'd65535);
    add_cfg(REG_STEP_SIZE, 16'd256);
    add_item(mk_cast(KIND_AIR, 32767, 0, 0, 32767, 0, 0), 1'b1,
             mk_res(STAT_MISS, 511, 0, 0, 1'b1, 0));
    add_item(mk_cast(KIND_AIR, -32768, 0, 0, -32768, 0, 0), 1'b1,
             mk_res(STAT_MISS, -512, 0, 0, 1'b1, 0));

    // hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (plan[r]) begin
      if (plan[r].what == ROW_CFG) begin
        settle();
        write_reg(plan[r].reg_index, plan[r].reg_value);
      end else begin
        push_item(plan[r].item, plan[r].typed, plan[r].res);
        sender_gap();
      end
    end

    // random phases, each under its own length and step; the last one runs
    // with no idling on either side
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_RAY_LENGTH, (phase_len[p] < 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'(phase_len[p]));
      write_reg(REG_STEP_SIZE, (phase_step[p] < 0) ? 16'($urandom_range(1, 2048))
                                                    : 16'(phase_step[p]));
      if (p == PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      repeat (phase_items[p]) begin
        push_item(random_item(), 1'b0, '0);
        sender_gap();
        // now and then let the block drain completely before going on
        if (p != PHASES - 1 && $urandom_range(0, 199) == 0) begin
          settle();
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (answers_q.size() != 0) begin
      $error("%0d answers left without a result item", answers_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/vrm_pkg.sv
rtl/core/vrm_store.sv
rtl/core/vrm_ctrl.sv
rtl/core/vrm_dp.sv
rtl/core/voxel_ray_march.sv
tb/sv/voxel_ray_march_tb.sv
